@@ rtl/core/oata_pkg.sv @@
package oata_pkg;

    localparam int unsigned CFG_IDX_WIDTH = 3;
    localparam int unsigned CFG_DATA_WIDTH = 48;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_NEGATE_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2     = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Z = 3'd7;

    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_CORNER = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CORDIC_WIDTH = 34;

    typedef logic signed [15:0] t_atan_tab [CORDIC_STEPS];
    localparam t_atan_tab ATAN_UNITS = '{
        16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163,
        16'sd81, 16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1, 16'sd1, 16'sd0
    };
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_X0 = 34'sd652032874;

endpackage

@@ rtl/core/oata_if.sv @@
interface oata_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] box_width;
    logic signed [COORD_WIDTH-1:0] box_height;
    logic signed [ANGLE_WIDTH-1:0] heading;
    logic                          has_vertex_list;

    modport source (output valid, kind, pos_x, pos_y, pos_z, box_width, box_height,
                    heading, has_vertex_list, input ready);
    modport sink (input valid, kind, pos_x, pos_y, pos_z, box_width, box_height,
                  heading, has_vertex_list, output ready);
endinterface

interface oata_out_if #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic signed [COORD_WIDTH-1:0] out_width;
    logic signed [COORD_WIDTH-1:0] out_height;
    logic signed [ANGLE_WIDTH-1:0] out_heading;
    logic                          last;

    modport source (output valid, result_kind, out_x, out_y, out_z, out_width, out_height,
                    out_heading, last, input ready);
    modport sink (input valid, result_kind, out_x, out_y, out_z, out_width, out_height,
                  out_heading, last, output ready);
endinterface

interface oata_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/oata_cordic.sv @@
// pipelined cordic: one rotation per register stage, enable shifts the whole line
module oata_cordic #(
    parameter int ANGLE_WIDTH = 16,
    parameter int TAG_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    input  logic [TAG_WIDTH-1:0]          i_tag,
    output logic signed [15:0]            o_cos,
    output logic signed [15:0]            o_sin,
    output logic [TAG_WIDTH-1:0]          o_tag
);
    import oata_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam int W = CORDIC_WIDTH;

    logic signed [W-1:0]    r_x [N+1];
    logic signed [W-1:0]    r_y [N+1];
    logic signed [17:0]     r_z [N+1];
    logic                   r_flip [N+1];
    logic [TAG_WIDTH-1:0]   r_tag [N+1];
    logic signed [15:0]     r_cos;
    logic signed [15:0]     r_sin;
    logic [TAG_WIDTH-1:0]   r_otag;

    logic [15:0]        a16;
    logic signed [17:0] z_in;
    logic signed [17:0] z_fold;
    logic               flip_in;

    always_comb begin
        if (ANGLE_WIDTH >= 16) begin
            a16 = i_angle[ANGLE_WIDTH-1 -: 16];
        end else begin
            a16 = 16'(i_angle) << (16 - ANGLE_WIDTH);
        end
        z_in = 18'(signed'(a16));
        flip_in = 1'b0;
        z_fold = z_in;
        if (z_in > 18'sd16384) begin
            z_fold = z_in - 18'sd32768;
            flip_in = 1'b1;
        end else if (z_in < -18'sd16384) begin
            z_fold = z_in + 18'sd32768;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= z_fold;
            r_flip[0] <= flip_in;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - 18'(ATAN_UNITS[g]);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + 18'(ATAN_UNITS[g]);
                end
                r_flip[g+1] <= r_flip[g];
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    logic signed [W-1:0]  cx, sy;
    logic signed [W-16:0] cq, sq;
    logic signed [15:0]   cc, sc;

    always_comb begin
        cx = r_x[N] + W'(32768);
        sy = r_y[N] + W'(32768);
        cq = (W-15)'(cx >>> 16);
        sq = (W-15)'(sy >>> 16);
        cc = (cq > 19'sd16384) ? 16'sd16384 : (cq < -19'sd16384) ? -16'sd16384 : 16'(cq);
        sc = (sq > 19'sd16384) ? 16'sd16384 : (sq < -19'sd16384) ? -16'sd16384 : 16'(sq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[N] ? -cc : cc;
            r_sin <= r_flip[N] ? -sc : sc;
            r_otag <= r_tag[N];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
    assign o_tag = r_otag;
endmodule

@@ rtl/core/oata_mapper.sv @@
// affine map of one point: 3 register stages (multiply, sum+round, offset+sat+negate)
module oata_mapper #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_enable,
    input  logic                          i_negate_y,
    input  logic [47:0]                   i_rows [3],
    input  logic signed [COORD_WIDTH-1:0] i_offs [3],
    input  logic signed [COORD_WIDTH+1:0] i_v [3],
    output logic signed [COORD_WIDTH-1:0] o_r [3]
);
    localparam int VW = COORD_WIDTH + 2;
    localparam int PW = VW + 17;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SW+1:0] HI = (SW+2)'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
    localparam logic signed [SW+1:0] LO = -HI - 1;

    logic signed [PW-1:0] r_prod [3][3];
    logic signed [VW-1:0] r_v1 [3];
    logic signed [SW-1:0] r_sum [3];
    logic signed [VW-1:0] r_v2 [3];
    logic                 r_en1, r_en2, r_neg1, r_neg2;
    logic signed [COORD_WIDTH-1:0] r_off1 [3];
    logic signed [COORD_WIDTH-1:0] r_off2 [3];
    logic signed [COORD_WIDTH-1:0] r_out [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[i][k] <= PW'(signed'(i_rows[i][47-16*k -: 16]) * i_v[k]);
                end
                r_v1[i] <= i_v[i];
                r_off1[i] <= i_offs[i];
            end
            r_en1 <= i_enable;
            r_neg1 <= i_negate_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= ((SW'(r_prod[i][0]) + SW'(r_prod[i][1]) + SW'(r_prod[i][2])
                             + HALF) >>> COEF_FRAC_BITS);
                r_v2[i] <= r_v1[i];
                r_off2[i] <= r_off1[i];
            end
            r_en2 <= r_en1;
            r_neg2 <= r_neg1;
        end
    end

    logic signed [SW+1:0] t [3];
    logic signed [SW+1:0] ty;
    logic signed [COORD_WIDTH-1:0] s [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i] = r_en2 ? ((SW+2)'(r_sum[i]) + (SW+2)'(r_off2[i])) : (SW+2)'(r_v2[i]);
            s[i] = (t[i] > HI) ? COORD_WIDTH'(HI) : (t[i] < LO) ? COORD_WIDTH'(LO)
                 : COORD_WIDTH'(t[i]);
        end
        ty = -(SW+2)'(s[1]);
        if (r_neg2) begin
            s[1] = (ty > HI) ? COORD_WIDTH'(HI) : COORD_WIDTH'(ty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= s;
        end
    end

    assign o_r = r_out;
endmodule

@@ rtl/core/obstacle_affine_transform_aabb_unit.sv @@
// obstacle affine transform unit
// channels: i_in (input items), o_out (result transactions), i_cfg (register writes).
// a point item or a rectangle that is not rebuilt gives one result; a rectangle with
// the matrix enabled, no vertex list and positive sizes gives four corners then a box
// record with last set.
// front end: a rectangle to rebuild is held while its other three corners are issued
// one per cycle while the output is not stalled, then one empty slot is left for the
// box record; points are taken at 1 item/cycle under the same condition, and a rebuilt
// rectangle blocks new items until its corners and box slot are issued, as there is a
// single shared affine mapper and one result channel.
// the result path holds 18 cordic stages, 1 corner stage, 3 mapper stages and the
// output register; the box record is the next result after its fourth corner.
// the whole pipeline advances only when the output register is empty or being taken,
// so a stall at the receiver freezes every stage and nothing is lost or repeated.
// reset (synchronous, active low) clears valid bits and restores the identity matrix.
// the user must write configuration only while the block is idle; the block does not enforce it.
module obstacle_affine_transform_aabb_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_FRAC_BITS = 14,
    parameter int ANGLE_WIDTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    oata_in_if.sink   i_in,
    oata_out_if.source o_out,
    oata_cfg_if.sink  i_cfg
);
    import oata_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int VW = CW + 2;

    // config
    logic        r_enable, r_neg;
    logic [47:0] r_rows [3];
    logic signed [CW-1:0] r_offs [3];

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_neg <= 1'b0;
            r_rows[0] <= 48'h4000_0000_0000;
            r_rows[1] <= 48'h0000_4000_0000;
            r_rows[2] <= 48'h0000_0000_4000;
            r_offs[0] <= '0;
            r_offs[1] <= '0;
            r_offs[2] <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENABLE:   r_enable <= i_cfg.data[0];
                REG_NEGATE_Y: r_neg <= i_cfg.data[0];
                REG_ROW0:     r_rows[0] <= i_cfg.data;
                REG_ROW1:     r_rows[1] <= i_cfg.data;
                REG_ROW2:     r_rows[2] <= i_cfg.data;
                REG_OFFSET_X: r_offs[0] <= CW'(i_cfg.data);
                REG_OFFSET_Y: r_offs[1] <= CW'(i_cfg.data);
                REG_OFFSET_Z: r_offs[2] <= CW'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic r_ovalid;
    logic adv;
    assign adv = !r_ovalid || o_out.ready;

    // tag carried through the cordic: valid, kind, rebuild, position, sizes and heading
    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic                 rebuild;
        logic signed [CW-1:0] x, y, z, w, h;
        logic [ANGLE_WIDTH-1:0] hd;
    } t_item;
    localparam int TW = $bits(t_item);

    t_item in_item, cd_item;
    logic signed [15:0] cd_cos, cd_sin;

    // front end holds a rebuilt rectangle for its remaining corners, then leaves a gap
    logic [1:0] r_cnt;
    logic       r_hold;
    logic       r_gap;
    logic       fe_busy;
    t_item      r_held;
    logic signed [15:0] r_c, r_s;

    assign fe_busy = r_hold || r_gap;
    assign i_in.ready = adv && !fe_busy;

    always_comb begin
        in_item.valid = i_in.valid && !fe_busy;
        in_item.kind = i_in.kind;
        in_item.rebuild = i_in.kind && r_enable && !i_in.has_vertex_list
                          && i_in.box_width > 0 && i_in.box_height > 0;
        in_item.x = i_in.pos_x;
        in_item.y = i_in.pos_y;
        in_item.z = i_in.pos_z;
        in_item.w = i_in.box_width;
        in_item.h = i_in.box_height;
        in_item.hd = i_in.heading;
    end

    oata_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TAG_WIDTH(TW)) u_cordic (
        .i_clk(i_clk), .i_en(adv && !fe_busy), .i_angle(i_in.heading),
        .i_tag(in_item), .o_cos(cd_cos), .o_sin(cd_sin), .o_tag(cd_item)
    );

    // valid bit of cordic output kept resettable separately
    logic [CORDIC_STEPS+1:0] r_cv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (adv && !fe_busy) begin
            r_cv <= {r_cv[CORDIC_STEPS:0], in_item.valid};
        end
    end

    // select current item and corner index
    t_item cur;
    logic signed [15:0] cur_c, cur_s;
    logic [1:0] cur_k;
    logic cur_v;
    always_comb begin
        if (r_hold) begin
            cur = r_held; cur_c = r_c; cur_s = r_s; cur_k = r_cnt; cur_v = 1'b1;
        end else begin
            cur = cd_item; cur_c = cd_cos; cur_s = cd_sin; cur_k = 2'd0;
            cur_v = r_cv[CORDIC_STEPS+1] && !r_gap;
        end
    end

    // the gap after corner 3 is the slot the box record takes at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_gap <= 1'b0;
            r_cnt <= '0;
        end else if (adv) begin
            if (r_hold) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_hold <= 1'b0;
                    r_gap <= 1'b1;
                end
            end else if (r_gap) begin
                r_gap <= 1'b0;
            end else if (cur_v && cur.rebuild) begin
                r_hold <= 1'b1;
                r_cnt <= 2'd1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv && !fe_busy) begin
            r_held <= cd_item; r_c <= cd_cos; r_s <= cd_sin;
        end
    end

    // corner stage a: products
    logic        r_av;
    t_item       r_ai;
    logic [1:0]  r_ak;
    logic signed [CW+16:0] r_wc, r_ws, r_hc, r_hs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (adv) r_av <= cur_v;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ai <= cur; r_ak <= cur_k;
            r_wc <= (CW+17)'(cur.w * cur_c);
            r_ws <= (CW+17)'(cur.w * cur_s);
            r_hc <= (CW+17)'(cur.h * cur_c);
            r_hs <= (CW+17)'(cur.h * cur_s);
        end
    end

    // corner stage b: offsets and mapper input
    logic signed [CW+18:0] ex, ey;
    logic signed [VW-1:0]  vin [3];
    always_comb begin
        unique case (r_ak)
            2'd0: begin ex = r_wc - r_hs; ey = r_ws + r_hc; end
            2'd1: begin ex = -r_wc - r_hs; ey = -r_ws + r_hc; end
            2'd2: begin ex = -r_wc + r_hs; ey = -r_ws - r_hc; end
            default: begin ex = r_wc + r_hs; ey = r_ws - r_hc; end
        endcase
        ex = (ex + (CW+19)'(16384)) >>> 15;
        ey = (ey + (CW+19)'(16384)) >>> 15;
        if (r_ai.rebuild) begin
            vin[0] = VW'(r_ai.x) + VW'(ex);
            vin[1] = VW'(r_ai.y) + VW'(ey);
        end else begin
            vin[0] = VW'(r_ai.x);
            vin[1] = VW'(r_ai.y);
        end
        vin[2] = VW'(r_ai.z);
    end

    // meta travels alongside the mapper (3 stages)
    typedef struct packed {
        logic                   valid;
        logic [1:0]             rk;
        logic                   last;
        logic [1:0]             k;
        logic signed [CW-1:0]   w, h;
        logic [ANGLE_WIDTH-1:0] hd;
    } t_meta;
    t_meta m_in;
    t_meta r_m [3];
    always_comb begin
        m_in.valid = r_av;
        m_in.k = r_ak;
        if (!r_ai.kind) begin
            m_in.rk = KIND_POINT; m_in.last = 1'b1;
            m_in.w = '0; m_in.h = '0; m_in.hd = '0;
        end else if (r_ai.rebuild) begin
            m_in.rk = KIND_CORNER; m_in.last = 1'b0;
            m_in.w = '0; m_in.h = '0; m_in.hd = '0;
        end else begin
            m_in.rk = KIND_RECORD; m_in.last = 1'b1;
            m_in.w = r_ai.w; m_in.h = r_ai.h; m_in.hd = r_ai.hd;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_m[i] <= '0;
        end else if (adv) begin
            r_m[0] <= m_in; r_m[1] <= r_m[0]; r_m[2] <= r_m[1];
        end
    end

    logic signed [CW-1:0] mr [3];
    oata_mapper #(.COORD_WIDTH(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mapper (
        .i_clk(i_clk), .i_en(adv), .i_enable(r_enable), .i_negate_y(r_neg),
        .i_rows(r_rows), .i_offs(r_offs), .i_v(vin), .o_r(mr)
    );

    // min/max accumulation over corners, box record issued after corner 3
    logic signed [CW-1:0] r_mnx, r_mxx, r_mny, r_mxy, r_z0;
    logic                 r_box;
    t_meta mo;
    assign mo = r_m[2];
    logic signed [CW-1:0] mnx, mxx, mny, mxy;
    always_comb begin
        if (mo.k == 2'd0) begin
            mnx = mr[0]; mxx = mr[0]; mny = mr[1]; mxy = mr[1];
        end else begin
            mnx = (mr[0] < r_mnx) ? mr[0] : r_mnx;
            mxx = (mr[0] > r_mxx) ? mr[0] : r_mxx;
            mny = (mr[1] < r_mny) ? mr[1] : r_mny;
            mxy = (mr[1] > r_mxy) ? mr[1] : r_mxy;
        end
    end

    // box computation from registered extremes
    localparam logic signed [CW:0] SHI = (CW+1)'((64'sd1 <<< (CW-1)) - 1);
    logic signed [CW:0] dx, dy, sx, sy;
    logic signed [CW-1:0] bw, bh;
    always_comb begin
        dx = (CW+1)'(r_mxx) - (CW+1)'(r_mnx);
        dy = (CW+1)'(r_mxy) - (CW+1)'(r_mny);
        sx = ((CW+1)'(r_mnx) + (CW+1)'(r_mxx)) >>> 1;
        sy = ((CW+1)'(r_mny) + (CW+1)'(r_mxy)) >>> 1;
        bw = (dx > SHI) ? CW'(SHI) : CW'(dx);
        bh = (dy > SHI) ? CW'(SHI) : CW'(dy);
    end

    // the box record takes the empty slot the front end leaves after corner 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_box <= 1'b0;
        end else if (adv) begin
            r_box <= mo.valid && mo.rk == KIND_CORNER && mo.k == 2'd3;
            r_ovalid <= mo.valid || r_box;
        end
    end

    logic [1:0] r_rk;
    logic r_last;
    logic signed [CW-1:0] r_ox, r_oy, r_oz, r_ow, r_oh;
    logic [ANGLE_WIDTH-1:0] r_ohd;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (mo.valid && mo.rk == KIND_CORNER) begin
                r_mnx <= mnx; r_mxx <= mxx; r_mny <= mny; r_mxy <= mxy;
                if (mo.k == 2'd0) r_z0 <= mr[2];
            end
            if (r_box) begin
                r_rk <= KIND_RECORD; r_last <= 1'b1;
                r_ox <= CW'(sx); r_oy <= CW'(sy); r_oz <= r_z0;
                r_ow <= bw; r_oh <= bh; r_ohd <= '0;
            end else begin
                r_rk <= mo.rk; r_last <= mo.last;
                r_ox <= mr[0]; r_oy <= mr[1]; r_oz <= mr[2];
                r_ow <= mo.w; r_oh <= mo.h; r_ohd <= mo.hd;
            end
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.result_kind = r_rk;
    assign o_out.out_x = r_ox;
    assign o_out.out_y = r_oy;
    assign o_out.out_z = r_oz;
    assign o_out.out_width = r_ow;
    assign o_out.out_height = r_oh;
    assign o_out.out_heading = r_ohd;
    assign o_out.last = r_last;
endmodule

@@ tb/sv/oata_tb_pkg.sv @@
`timescale 1ns / 100ps
package oata_tb_pkg;

    typedef struct packed {
        logic [1:0]         rkind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic signed [15:0] hd;
        logic               last;
    } t_result;

endpackage

@@ tb/sv/oata_tb_checker.sv @@
`timescale 1ns / 100ps
module oata_tb_checker
    import oata_pkg::*;
    import oata_tb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    oata_in_if   in_ch,
    oata_out_if  out_ch,
    oata_cfg_if  cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    logic        enable_r;
    logic        neg_y_r;
    logic [47:0] rows_r [3];
    logic signed [31:0] offs_r [3];
    t_result     expected_q [$];
    int          errors;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    assign o_errors  = errors;
    assign o_pending = expected_q.size();

    function automatic longint sat32(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // row dot product, rounded half up at the coefficient fraction point
    function automatic longint row_sum(input logic [47:0] packed_row, input longint v [3]);
        longint acc;
        longint c;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            c = longint'($signed(packed_row[47-16*k -: 16]));
            acc += c * v[k];
        end
        return (acc + 64'sd8192) >>> 14;
    endfunction

    task automatic map_point(input longint v [3], output longint r [3]);
        for (int i = 0; i < 3; i++) begin
            if (enable_r) begin
                r[i] = sat32(row_sum(rows_r[i], v) + longint'(offs_r[i]));
            end else begin
                r[i] = sat32(v[i]);
            end
        end
        if (neg_y_r) begin
            r[1] = sat32(-r[1]);
        end
    endtask

    task automatic heading_cos_sin(input logic [15:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'($signed(ang));
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 16384) begin
            z -= 32768;
            flip = 1;
        end else if (z < -16384) begin
            z += 32768;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_UNITS[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_UNITS[i]);
            end
        end
        c = (x + 32768) >>> 16;
        s = (y + 32768) >>> 16;
        c = c > 16384 ? 16384 : (c < -16384 ? -16384 : c);
        s = s > 16384 ? 16384 : (s < -16384 ? -16384 : s);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic t_result make_result(input logic [1:0] k, input longint p [3],
                                            input longint w, input longint h,
                                            input logic [15:0] hd, input logic lst);
        t_result r;
        r.rkind = k;
        r.x = p[0][31:0];
        r.y = p[1][31:0];
        r.z = p[2][31:0];
        r.w = w[31:0];
        r.h = h[31:0];
        r.hd = hd;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_item();
        longint pos [3];
        longint res [3];
        longint corner [3];
        longint box [3];
        longint w;
        longint h;
        longint c;
        longint s;
        longint ex;
        longint ey;
        longint mnx;
        longint mxx;
        longint mny;
        longint mxy;
        longint z0;
        int     sx [4];
        int     sy [4];
        sx = '{1, -1, -1, 1};
        sy = '{1, 1, -1, -1};
        pos[0] = longint'(in_ch.pos_x);
        pos[1] = longint'(in_ch.pos_y);
        pos[2] = longint'(in_ch.pos_z);
        w = longint'(in_ch.box_width);
        h = longint'(in_ch.box_height);
        mnx = 0; mxx = 0; mny = 0; mxy = 0; z0 = 0;
        if (in_ch.kind == 1'b0) begin
            map_point(pos, res);
            expected_q.push_back(make_result(KIND_POINT, res, 0, 0, '0, 1'b1));
        end else if (enable_r && !in_ch.has_vertex_list && w > 0 && h > 0) begin
            heading_cos_sin(in_ch.heading, c, s);
            for (int k = 0; k < 4; k++) begin
                ex = sx[k] * w * c - sy[k] * h * s;
                ey = sx[k] * w * s + sy[k] * h * c;
                corner[0] = pos[0] + ((ex + 16384) >>> 15);
                corner[1] = pos[1] + ((ey + 16384) >>> 15);
                corner[2] = pos[2];
                map_point(corner, res);
                expected_q.push_back(make_result(KIND_CORNER, res, 0, 0, '0, 1'b0));
                if (k == 0) begin
                    mnx = res[0]; mxx = res[0]; mny = res[1]; mxy = res[1]; z0 = res[2];
                end else begin
                    if (res[0] < mnx) mnx = res[0];
                    if (res[0] > mxx) mxx = res[0];
                    if (res[1] < mny) mny = res[1];
                    if (res[1] > mxy) mxy = res[1];
                end
            end
            box[0] = (mnx + mxx) >>> 1;
            box[1] = (mny + mxy) >>> 1;
            box[2] = z0;
            expected_q.push_back(make_result(KIND_RECORD, box, sat32(mxx - mnx),
                                             sat32(mxy - mny), '0, 1'b1));
        end else begin
            map_point(pos, res);
            expected_q.push_back(make_result(KIND_RECORD, res, w, h, in_ch.heading, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            enable_r <= 1'b0;
            neg_y_r  <= 1'b0;
            rows_r[0] <= 48'h4000_0000_0000;
            rows_r[1] <= 48'h0000_4000_0000;
            rows_r[2] <= 48'h0000_0000_4000;
            offs_r[0] <= '0;
            offs_r[1] <= '0;
            offs_r[2] <= '0;
            expected_q.delete();
            errors = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_ENABLE:   enable_r  <= cfg_ch.data[0];
                    REG_NEGATE_Y: neg_y_r   <= cfg_ch.data[0];
                    REG_ROW0:     rows_r[0] <= cfg_ch.data;
                    REG_ROW1:     rows_r[1] <= cfg_ch.data;
                    REG_ROW2:     rows_r[2] <= cfg_ch.data;
                    REG_OFFSET_X: offs_r[0] <= cfg_ch.data[31:0];
                    REG_OFFSET_Y: offs_r[1] <= cfg_ch.data[31:0];
                    REG_OFFSET_Z: offs_r[2] <= cfg_ch.data[31:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.result_kind, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                        out_ch.out_width, out_ch.out_height, out_ch.out_heading,
                        out_ch.last};
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transaction %p", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_item();
            end
        end
    end

endmodule

@@ tb/sv/obstacle_affine_transform_aabb_unit_tb.sv @@
`timescale 1ns / 100ps
module obstacle_affine_transform_aabb_unit_tb;
    import oata_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   sender_on;
    int   stall_mode;

    oata_in_if  in_ch ();
    oata_out_if out_ch ();
    oata_cfg_if cfg_ch ();

    obstacle_affine_transform_aabb_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    oata_tb_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // receiver stall pattern: phases of always ready, random and mostly stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_item(input logic kind, input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] w,
                             input logic [31:0] h, input logic [15:0] hd,
                             input logic vlist);
        int gap;
        if (!sender_on) begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            sender_on = 1;
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        in_ch.pos_z <= pz;
        in_ch.box_width <= w;
        in_ch.box_height <= h;
        in_ch.heading <= hd;
        in_ch.has_vertex_list <= vlist;
        do @(posedge i_clk); while (!in_ch.ready);
        if ($urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            sender_on = 0;
        end
    endtask

    task automatic end_burst();
        if (sender_on) begin
            in_ch.valid <= 1'b0;
            sender_on = 0;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
    endfunction

    task automatic random_config(input bit extreme);
        write_reg(REG_ENABLE, 48'($urandom_range(0, 4) != 0));
        write_reg(REG_NEGATE_Y, 48'($urandom_range(0, 1)));
        for (int r = 0; r < 3; r++) begin
            write_reg(3'(int'(REG_ROW0) + r),
                      extreme ? {3{($urandom_range(0, 1) ? 16'h7fff : 16'h8000)}}
                              : {rand_coef(), rand_coef(), rand_coef()});
        end
        write_reg(REG_OFFSET_X, {16'h0, rand_coord()});
        write_reg(REG_OFFSET_Y, {16'hffff, rand_coord()});
        write_reg(REG_OFFSET_Z, {16'h0, rand_coord()});
    endtask

    task automatic random_item();
        logic        kind;
        logic [31:0] w;
        logic [31:0] h;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) != 0) begin
            w = $urandom_range(1, 32'h0100_0000);
            h = $urandom_range(1, 32'h0100_0000);
        end else begin
            w = rand_coord();
            h = rand_coord();
        end
        send_item(kind, rand_coord(), rand_coord(), rand_coord(), w, h, 16'($urandom()),
                  ($urandom_range(0, 7) == 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        sender_on = 0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.box_width = '0;
        in_ch.box_height = '0;
        in_ch.heading = '0;
        in_ch.has_vertex_list = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ENABLE;
        cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset identity, matrix off
        send_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0);
        send_item(1'b1, 32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000, 32'h0001_0000,
                  16'h1234, 0);
        end_burst();
        wait_drained();

        write_reg(REG_ENABLE, 48'd1);
        write_reg(REG_NEGATE_Y, 48'd1);
        // minimum Y negated saturates
        send_item(1'b0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_item(1'b0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h0000, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h4000, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h7fff, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h8000, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'h4001, 0);
        send_item(1'b1, 0, 0, 0, 32'h0002_0000, 32'h0001_0000, 16'hbfff, 0);
        // rebuild near the coordinate limits
        send_item(1'b1, 32'h7fff_0000, 32'h8000_1000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 16'h2000, 0);
        // not rebuilt: vertex list, zero size, negative size
        send_item(1'b1, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 16'h0100, 1);
        send_item(1'b1, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 16'h0100, 0);
        send_item(1'b1, 32'h0001_0000, 0, 0, 32'h8000_0000, 32'hffff_ffff, 16'hffff, 0);
        end_burst();
        wait_drained();

        random_config(1);
        write_reg(REG_ENABLE, 48'd1);
        write_reg(REG_OFFSET_X, 48'h0000_7fff_ffff);
        write_reg(REG_OFFSET_Y, 48'h0000_8000_0000);
        for (int i = 0; i < 6; i++) random_item();
        end_burst();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            random_config(0);
            for (int i = 0; i < 22; i++) random_item();
            end_burst();
            wait_drained();
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
